[design/alr_pkg.sv]
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the antialiased line rasteriser
// Sequencer states and the fixed gradient format.
// ----------------------------------------------------------------------------
`default_nettype none

package alr_pkg;

  // fractional bits of the gradient
  localparam int unsigned GRAD_BITS = 16;
  // quotient bits produced by the divider (gradient magnitude up to 1.0)
  localparam int unsigned QUO_BITS  = GRAD_BITS + 1;
  // signed width of a minor-axis position
  localparam int unsigned POS_W     = 35;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SETUP  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_PREP   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

[design/alr_div.sv]
// ----------------------------------------------------------------------------
// alr_div: gradient divider
// Restoring divider giving (num << 16) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_div import alr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [15:0]         num_i,
  input  wire logic [15:0]         den_i,
  output logic      [QUO_BITS-1:0] quo_o,
  output logic                     done_o
);

  localparam int unsigned CNT_W = $clog2(QUO_BITS);

  logic [16:0]         rem_q, rem_d;
  logic [QUO_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [15:0]         den_q, den_d;
  logic                lsb_q, lsb_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [17:0]         trial;
  logic                qbit;

  // one restoring step; dividend bits below the numerator are zero
  always_comb begin
    trial = {rem_q, (cnt_q == CNT_W'(QUO_BITS - 1)) ? lsb_q : 1'b0};
    qbit  = (trial >= {2'b00, den_q});
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    den_d = den_q;
    lsb_d = lsb_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // numerator >> 1 is already below the divisor
      rem_d  = {2'b00, num_i[15:1]};
      lsb_d  = num_i[0];
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = CNT_W'(QUO_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? 17'(trial - {2'b00, den_q}) : trial[16:0];
      quo_d = {quo_q[QUO_BITS-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    lsb_q <= lsb_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[design/antialiased_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_core: Wu antialiased line rasteriser
// Turns one line segment into a run of pixel pairs with alphas.
// ----------------------------------------------------------------------------
// A line goes through set-up (ST_SETUP, then ST_DIVIDE in the bit-serial
// gradient divider, then ST_PREP) and then gives one output beat per cycle
// while the output side does not stall, one for each major-axis column (two
// endpoint beats, then the interior columns, at most MAX_COLUMNS). The input
// is ready only between lines.
`default_nettype none

module antialiased_line_rasterizer_core import alr_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = 64,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] start_x_i,
  input  wire logic [15:0] start_y_i,
  input  wire logic [15:0] end_x_i,
  input  wire logic [15:0] end_y_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  intensity_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [12:0]      pixel_x_o,
  output logic [12:0]      pixel_y_o,
  output logic             pair_along_x_o,
  output logic [7:0]       alpha_near_o,
  output logic [7:0]       alpha_far_o,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic             last_column_o,
  output logic             truncated_o
);

  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned POS   = FB + GRAD_BITS;
  localparam int unsigned XW    = 17;
  localparam int unsigned CW    = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned GAPW  = FB + 1;
  localparam int unsigned GIW   = GAPW + 8;
  localparam int unsigned OFFW  = FB + 1;
  localparam int unsigned PGW   = QUO_BITS + 1 + OFFW;
  localparam int unsigned MW    = POS + 1 + GIW;
  localparam logic [16:0] HALF  = 17'(1 << (FB - 1));
  localparam logic [GAPW-1:0] ONE = GAPW'(1 << FB);

  state_e state_q, state_d;

  // captured beat
  logic [15:0] ix0_q, iy0_q, ix1_q, iy1_q;
  logic [7:0]  red_q, green_q, blue_q, inten_q;
  // normalised line
  logic [15:0] x0_q, y0_q, x1_q, y1_q, dx_q;
  logic        neg_q, steep_q;
  // per-line constants
  logic signed [QUO_BITS:0] grad_q;
  logic signed [POS_W-1:0]  ye1_q, ye2_q, acc_q, gstep_q;
  logic [XW-1:0]            xe1_q, xe2_q, maj_q;
  logic [GIW-1:0]           gi1_q, gi2_q, gii_q;
  logic [CW-1:0]            count_q, col_q;
  logic                     trunc_q;
  // output register
  logic        ovalid_q;
  logic [12:0] px_q, py_q;
  logic [7:0]  an_q, af_q;
  logic [7:0]  ored_q, ogrn_q, oblu_q;
  logic        pax_q;
  logic        last_q, trc_q;

  logic                div_start, div_done;
  logic [QUO_BITS-1:0] quo;

  assign div_start = (state_q == ST_SETUP);

  // set-up: steepness, axis swap and endpoint order
  logic [16:0] adx_c, ady_c;
  logic        steep_c, swap_c;
  logic [15:0] a0, b0, a1, b1, dxn_c, adyn_c;
  always_comb begin
    adx_c   = (ix1_q >= ix0_q) ? 17'(ix1_q - ix0_q) : 17'(ix0_q - ix1_q);
    ady_c   = (iy1_q >= iy0_q) ? 17'(iy1_q - iy0_q) : 17'(iy0_q - iy1_q);
    steep_c = ady_c > adx_c;
    a0 = steep_c ? iy0_q : ix0_q;
    b0 = steep_c ? ix0_q : iy0_q;
    a1 = steep_c ? iy1_q : ix1_q;
    b1 = steep_c ? ix1_q : iy1_q;
    swap_c = a0 > a1;
    // span and minor magnitude feed the divider straight away
    dxn_c  = swap_c ? 16'(a0 - a1) : 16'(a1 - a0);
    adyn_c = (b1 >= b0) ? 16'(b1 - b0) : 16'(b0 - b1);
  end

  alr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (adyn_c),
    .den_i  (dxn_c),
    .quo_o  (quo),
    .done_o (div_done)
  );

  // prep: endpoint rounding, gaps, positions and column count
  logic [16:0]              s1, s2;
  logic [FB-1:0]            f1, f2;
  logic signed [QUO_BITS:0] grad_c;
  logic signed [OFFW-1:0]   off1, off2;
  logic signed [PGW-1:0]    pg1, pg2;
  logic signed [POS_W-1:0]  ye1_c, ye2_c, gstep_c;
  logic [GAPW-1:0]          gap1, gap2;
  logic [XW-1:0]            xe1_c, xe2_c, diff;
  logic                     trunc_c;
  logic [CW-1:0]            count_c;
  always_comb begin
    s1 = {1'b0, x0_q} + HALF;
    s2 = {1'b0, x1_q} + HALF;
    f1 = s1[FB-1:0];
    f2 = s2[FB-1:0];
    xe1_c = XW'(s1 >> FB);
    xe2_c = XW'(s2 >> FB);
    if (dx_q == '0) begin
      grad_c = (QUO_BITS + 1)'(1 << GRAD_BITS);
    end else if (neg_q) begin
      grad_c = -$signed({1'b0, quo});
    end else begin
      grad_c = $signed({1'b0, quo});
    end
    off1 = $signed(OFFW'(HALF)) - $signed({1'b0, f1});
    off2 = $signed(OFFW'(HALF)) - $signed({1'b0, f2});
    pg1  = PGW'(grad_c) * PGW'(off1);
    pg2  = PGW'(grad_c) * PGW'(off2);
    ye1_c = ($signed(POS_W'({1'b0, y0_q})) <<< GRAD_BITS) + POS_W'(pg1);
    ye2_c = ($signed(POS_W'({1'b0, y1_q})) <<< GRAD_BITS) + POS_W'(pg2);
    gstep_c = POS_W'(grad_c) <<< FB;
    gap1 = ONE - GAPW'(f1);
    gap2 = GAPW'(f2);
    diff = xe2_c - xe1_c;
    trunc_c = diff >= XW'(MAX_COLUMNS);
    if (diff == '0) begin
      count_c = CW'(2);
    end else if (trunc_c) begin
      count_c = CW'(MAX_COLUMNS);
    end else begin
      count_c = CW'(diff + XW'(1));
    end
  end

  // column datapath: pick the column, split the position, weight the alphas
  logic signed [POS_W-1:0] pos;
  logic [XW-1:0]           maj;
  logic [GIW-1:0]          gi;
  logic [12:0]             mn, mj;
  logic [POS-1:0]          fr;
  logic [POS:0]            wn, wf;
  logic [MW-1:0]           mn_p, mf_p;
  logic                    last_c;
  always_comb begin
    if (col_q == CW'(0)) begin
      pos = ye1_q; maj = xe1_q; gi = gi1_q;
    end else if (col_q == CW'(1)) begin
      pos = ye2_q; maj = xe2_q; gi = gi2_q;
    end else begin
      pos = acc_q; maj = maj_q; gi = gii_q;
    end
    mn   = 13'(pos >>> POS);
    mj   = maj[12:0];
    fr   = pos[POS-1:0];
    wn   = {1'b1, {POS{1'b0}}} - {1'b0, fr};
    wf   = {1'b0, fr};
    mn_p = MW'(wn) * MW'(gi);
    mf_p = MW'(wf) * MW'(gi);
    last_c = (col_q == count_q - CW'(1));
  end

  logic load;
  assign load = (state_q == ST_EMIT) && (!ovalid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_d = ST_PREP;
      ST_PREP:   state_d = ST_EMIT;
      ST_EMIT:   if (load && last_c) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      col_q    <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == ST_PREP) begin
        col_q <= '0;
      end else if (load) begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ix0_q <= start_x_i; iy0_q <= start_y_i;
      ix1_q <= end_x_i;   iy1_q <= end_y_i;
      red_q <= red_i; green_q <= green_i; blue_q <= blue_i;
      inten_q <= intensity_i;
    end
    if (state_q == ST_SETUP) begin
      steep_q <= steep_c;
      dx_q    <= dxn_c;
      if (swap_c) begin
        x0_q <= a1; y0_q <= b1; x1_q <= a0; y1_q <= b0;
        neg_q <= b0 < b1;
      end else begin
        x0_q <= a0; y0_q <= b0; x1_q <= a1; y1_q <= b1;
        neg_q <= b1 < b0;
      end
    end
    if (state_q == ST_PREP) begin
      grad_q  <= grad_c;
      ye1_q   <= ye1_c;
      ye2_q   <= ye2_c;
      gstep_q <= gstep_c;
      acc_q   <= ye1_c + gstep_c;
      xe1_q   <= xe1_c;
      xe2_q   <= xe2_c;
      maj_q   <= xe1_c + XW'(1);
      gi1_q   <= GIW'(gap1) * GIW'(inten_q);
      gi2_q   <= GIW'(gap2) * GIW'(inten_q);
      gii_q   <= GIW'(ONE) * GIW'(inten_q);
      count_q <= count_c;
      trunc_q <= trunc_c;
    end else if (load && col_q >= CW'(2)) begin
      acc_q <= acc_q + gstep_q;
      maj_q <= maj_q + XW'(1);
    end
    // whole beat held here, so the next line can be taken in meanwhile
    if (load) begin
      px_q   <= steep_q ? mn : mj;
      py_q   <= steep_q ? mj : mn;
      an_q   <= mn_p[POS+FB +: 8];
      af_q   <= mf_p[POS+FB +: 8];
      ored_q <= red_q;
      ogrn_q <= green_q;
      oblu_q <= blue_q;
      pax_q  <= steep_q;
      last_q <= last_c;
      trc_q  <= last_c && trunc_q;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pair_along_x_o = pax_q;
  assign alpha_near_o   = an_q;
  assign alpha_far_o    = af_q;
  assign out_red_o      = ored_q;
  assign out_green_o    = ogrn_q;
  assign out_blue_o     = oblu_q;
  assign last_column_o  = last_q;
  assign truncated_o    = trc_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready straight after an accepted beat");

  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && truncated_o) |-> last_column_o)
    else $error("truncated flag away from the last beat");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("divider finished outside the divide phase");

  a_grad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (grad_q <= $signed((QUO_BITS + 1)'(1 << GRAD_BITS))))
    else $error("gradient above one");

endmodule

`default_nettype wire

[sim/alr_checker.sv]
// ----------------------------------------------------------------------------
// alr_checker: scoreboard for the antialiased line rasteriser
// Watches both channels, works out the pixel-pair beats of each accepted
// line and compares every output beat with the oldest one outstanding.
// ----------------------------------------------------------------------------
module alr_checker #(
  parameter int unsigned MAX_COLUMNS   = 64,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  input  logic [15:0] end_x_i,
  input  logic [15:0] end_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  intensity_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [12:0] pixel_x_i,
  input  logic [12:0] pixel_y_i,
  input  logic        pair_along_x_i,
  input  logic [7:0]  alpha_near_i,
  input  logic [7:0]  alpha_far_i,
  input  logic [7:0]  out_red_i,
  input  logic [7:0]  out_green_i,
  input  logic [7:0]  out_blue_i,
  input  logic        last_column_i,
  input  logic        truncated_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRAD_B = 16;
  localparam int POS_B  = FRACTION_BITS + GRAD_B;

  typedef struct packed {
    logic [12:0] px;
    logic [12:0] py;
    logic        along_x;
    logic [7:0]  a_near;
    logic [7:0]  a_far;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
    logic        trunc;
  } pair_beat_t;

  pair_beat_t pair_q[$];

  assign pending_o = pair_q.size();

  function automatic longint floor_minor(longint v);
    if (v >= 0) return v >>> POS_B;
    return -(((-v) + ((longint'(1) << POS_B) - 1)) >>> POS_B);
  endfunction

  function automatic pair_beat_t make_pair(longint major, longint minor, longint gap,
                                           bit steep, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b, logic [7:0] inten);
    pair_beat_t p;
    longint onep, fl, fr;
    longint unsigned nw, fw;
    onep = longint'(1) << POS_B;
    fl = floor_minor(minor);
    fr = minor - fl * onep;
    nw = (onep - fr) * gap * inten;
    fw = fr * gap * inten;
    p.px = steep ? fl[12:0] : major[12:0];
    p.py = steep ? major[12:0] : fl[12:0];
    p.along_x = steep;
    p.a_near = 8'((nw >> (POS_B + FRACTION_BITS)));
    p.a_far = 8'((fw >> (POS_B + FRACTION_BITS)));
    p.r = r; p.g = g; p.b = b;
    p.last = 1'b0; p.trunc = 1'b0;
    return p;
  endfunction

  // expand one line segment into its column beats
  task automatic rasterise_line();
    longint x0, y0, x1, y1, t, dx, dy, adx, ady, grad, one, half;
    longint xe1, ye1, gap1, xe2, ye2, gap2, cnt;
    bit steep, cut;
    pair_beat_t p;
    x0 = start_x_i; y0 = start_y_i; x1 = end_x_i; y1 = end_y_i;
    one = longint'(1) << FRACTION_BITS;
    half = longint'(1) << (FRACTION_BITS - 1);
    adx = x1 - x0; if (adx < 0) adx = -adx;
    ady = y1 - y0; if (ady < 0) ady = -ady;
    steep = ady > adx;
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    if (dx == 0) grad = longint'(1) << GRAD_B;
    else begin
      grad = ((dy < 0 ? -dy : dy) << GRAD_B) / dx;
      if (dy < 0) grad = -grad;
    end
    xe1 = (x0 + half) >>> FRACTION_BITS;
    ye1 = y0 * (longint'(1) << GRAD_B) + grad * (xe1 * one - x0);
    gap1 = one - ((x0 + half) & (one - 1));
    xe2 = (x1 + half) >>> FRACTION_BITS;
    ye2 = y1 * (longint'(1) << GRAD_B) + grad * (xe2 * one - x1);
    gap2 = (x1 + half) & (one - 1);
    cnt = xe2 - xe1 - 1;
    if (cnt < 0) cnt = 0;
    cnt += 2;
    cut = cnt > MAX_COLUMNS;
    if (cut) cnt = MAX_COLUMNS;
    for (longint c = 0; c < cnt; c++) begin
      if (c == 0)
        p = make_pair(xe1, ye1, gap1, steep, red_i, green_i, blue_i, intensity_i);
      else if (c == 1)
        p = make_pair(xe2, ye2, gap2, steep, red_i, green_i, blue_i, intensity_i);
      else
        p = make_pair(xe1 + c - 1, ye1 + grad * one * (c - 1), one, steep,
                      red_i, green_i, blue_i, intensity_i);
      if (c == cnt - 1) begin
        p.last = 1'b1;
        p.trunc = cut;
      end
      pair_q.push_back(p);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    pair_beat_t got, want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{pixel_x_i, pixel_y_i, pair_along_x_i, alpha_near_i, alpha_far_i,
                out_red_i, out_green_i, out_blue_i, last_column_i, truncated_i};
        if (pair_q.size() == 0) begin
          $display("%0t: unexpected output beat %p", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pair_q.pop_front();
          if (got !== want) begin
            $display("%0t: beat mismatch expected %p actual %p", $time, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) rasterise_line();
    end
  end
endmodule

[sim/tb_antialiased_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// tb_antialiased_line_rasterizer_core: stimulus for the line rasteriser
// Drives directed and random line segments with random gaps and output
// stalls; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_antialiased_line_rasterizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 360;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic [7:0]  red_i = '0, green_i = '0, blue_i = '0, intensity_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [12:0] pixel_x_o, pixel_y_o;
  logic        pair_along_x_o, last_column_o, truncated_o;
  logic [7:0]  alpha_near_o, alpha_far_o, out_red_o, out_green_o, out_blue_o;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  always #10 clk_i = ~clk_i;

  antialiased_line_rasterizer_core dut (.*);

  alr_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .red_i, .green_i, .blue_i, .intensity_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pixel_x_i(pixel_x_o), .pixel_y_i(pixel_y_o), .pair_along_x_i(pair_along_x_o),
    .alpha_near_i(alpha_near_o), .alpha_far_i(alpha_far_o),
    .out_red_i(out_red_o), .out_green_i(out_green_o), .out_blue_i(out_blue_o),
    .last_column_i(last_column_o), .truncated_i(truncated_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls, none during the calm stretch
  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 13);

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one line and hold it until accepted; valid stays up on return
  task automatic send_line(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                           logic [15:0] ey, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [7:0] inten);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    start_x_i <= sx; start_y_i <= sy; end_x_i <= ex; end_y_i <= ey;
    red_i <= r; green_i <= g; blue_i <= b; intensity_i <= inten;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // short line near a random anchor, occasionally long or full range
  task automatic send_random();
    logic [15:0] sx, sy, ex, ey;
    int sel;
    sel = $urandom_range(99);
    sx = $urandom; sy = $urandom;
    if (sel < 10) begin
      ex = $urandom; ey = $urandom;
    end else begin
      ex = sx + 16'($urandom_range(400)) - 16'd200;
      ey = sy + 16'($urandom_range(400)) - 16'd200;
    end
    send_line(sx, sy, ex, ey, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: zero length, one column, flat, steep, edges, truncation
    send_line(16'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd0, 8'd255, 8'd255);
    send_line(16'd100, 16'd50, 16'd104, 16'd60, 8'd1, 8'd2, 8'd3, 8'd128);
    send_line(16'd0, 16'd0, 16'd320, 16'd0, 8'd10, 8'd20, 8'd30, 8'd255);
    send_line(16'd0, 16'd0, 16'd320, 16'd320, 8'd0, 8'd0, 8'd0, 8'd255);
    send_line(16'd0, 16'd0, 16'd80, 16'd600, 8'd9, 8'd9, 8'd9, 8'd200);
    send_line(16'd600, 16'd400, 16'd0, 16'd0, 8'd5, 8'd6, 8'd7, 8'd77);
    send_line(16'd3, 16'd0, 16'd300, 16'd7, 8'd5, 8'd6, 8'd7, 8'd255);
    send_line(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_line(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_line(16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFFF, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_line(16'd0, 16'd1000, 16'd1008, 16'd1000, 8'd1, 8'd1, 8'd1, 8'd0);
    send_line(16'd0, 16'd7, 16'd500, 16'd0, 8'd3, 8'd3, 8'd3, 8'd255);
    send_line(16'd1000, 16'd0, 16'd1000, 16'd9, 8'd4, 8'd4, 8'd4, 8'd255);
    send_line(16'd8, 16'd8, 16'd1023, 16'd1031, 8'd7, 8'd8, 8'd9, 8'd1);
    // hold off until the directed lines are drained
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 150 && i < 200);
      send_random();
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[sim.f]
design/alr_pkg.sv
design/alr_div.sv
design/antialiased_line_rasterizer_core.sv
sim/alr_checker.sv
sim/tb_antialiased_line_rasterizer_core.sv
